@@ hdl/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

    // Widths of the request and response fields.
    localparam int OP_W     = 2;
    localparam int BASE_W   = 16;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 2;
    // Width of the stored block order.
    localparam int ORD_W    = 5;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request kinds.
    localparam op_t OP_ALLOC = 2'd0;
    localparam op_t OP_FREE  = 2'd1;
    localparam op_t OP_ADD   = 2'd2;

    // Response status codes.
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_BAD     = 2'd2;

endpackage

`default_nettype wire

@@ hdl/buddy_page_allocator.sv @@
`default_nettype none

// Buddy page allocator. Free memory is kept as power-of-two blocks, aligned to
// their own size, on one last-in first-out list per order; the list links and
// the per-page head flags live in two synchronous memories indexed by page,
// each with one read and one write port, so every list update is a read
// followed by a write. One request is handled at a time and answered with one
// response. After reset the block clears the head-flag memory, one page per
// cycle, and accepts no request until that pass is done. A freed or added
// range first has the flag of each of its pages cleared; then every block
// released is picked, its buddy probed at each order, a free buddy unlinked
// and merged, and the result pushed on its list. An allocation unlinks one
// block and releases its unused suffix the same way. A new request may be
// accepted while the previous response still waits to be taken.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536,
    parameter int MAX_ORDER = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [BASE_W-1:0]   base_page,
    input  wire logic [COUNT_W-1:0]  page_count,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [BASE_W-1:0]        alloc_base,
    output logic [COUNT_W-1:0]       free_total
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int LW  = $clog2(NUM_PAGES + 1);
    localparam int OI  = $clog2(MAX_ORDER + 1);
    localparam int W1  = (LW > MAX_ORDER + 1) ? LW : MAX_ORDER + 1;
    localparam int W2  = (W1 > COUNT_W) ? W1 : COUNT_W;
    localparam int WW  = W2 + 1;
    localparam int FW  = ORD_W + 1;
    localparam logic [LW-1:0] NO_PAGE = LW'(NUM_PAGES);
    localparam logic [WW-1:0] NP_W    = WW'(NUM_PAGES);

    // Sequencer states.
    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DEC      = 5'd2;
    localparam logic [4:0] S_SWEEP    = 5'd3;
    localparam logic [4:0] S_U_RD     = 5'd4;
    localparam logic [4:0] S_U_WR     = 5'd5;
    localparam logic [4:0] S_U_PV_RD  = 5'd6;
    localparam logic [4:0] S_U_PV_WR  = 5'd7;
    localparam logic [4:0] S_U_NX_RD  = 5'd8;
    localparam logic [4:0] S_U_NX_WR  = 5'd9;
    localparam logic [4:0] S_A_TAIL   = 5'd10;
    localparam logic [4:0] S_R_START  = 5'd11;
    localparam logic [4:0] S_M_START  = 5'd12;
    localparam logic [4:0] S_M_CHK    = 5'd13;
    localparam logic [4:0] S_P_WR     = 5'd14;
    localparam logic [4:0] S_P_TOP_RD = 5'd15;
    localparam logic [4:0] S_P_TOP_WR = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;
    localparam logic [4:0] S_OUT      = 5'd18;

    // Where an unlink returns to.
    localparam logic RET_ALLOC = 1'b1;
    localparam logic RET_MERGE = 1'b0;

    // Page-indexed stores: head flag with order, and the two list links.
    logic [FW-1:0]   flag_mem [NUM_PAGES];
    logic [2*LW-1:0] link_mem [NUM_PAGES];
    logic [FW-1:0]   fm_rd_reg;
    logic [2*LW-1:0] lm_rd_reg;

    logic            fm_we;
    logic [PW-1:0]   fm_waddr;
    logic [FW-1:0]   fm_wdata;
    logic            lm_we;
    logic [PW-1:0]   lm_waddr;
    logic [2*LW-1:0] lm_wdata;
    logic [PW-1:0]   mem_raddr;

    // Control and payload registers.
    logic [4:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [LW-1:0]       blk_reg, blk_next;
    logic [PW-1:0]       u_idx_reg, u_idx_next;
    logic [OI-1:0]       u_ord_reg, u_ord_next;
    logic [LW-1:0]       nx_reg, nx_next;
    logic [LW-1:0]       pv_reg, pv_next;
    logic                ret_reg, ret_next;
    logic [PW-1:0]       m_idx_reg, m_idx_next;
    logic [OI-1:0]       m_ord_reg, m_ord_next;
    logic [LW-1:0]       top_reg, top_next;
    logic [WW-1:0]       rel_idx_reg, rel_idx_next;
    logic [WW-1:0]       rel_n_reg, rel_n_next;
    logic [PW-1:0]       sw_addr_reg, sw_addr_next;
    logic [WW-1:0]       sw_left_reg, sw_left_next;
    logic [LW-1:0]       lt_reg [MAX_ORDER+1];
    logic [LW-1:0]       lt_next [MAX_ORDER+1];
    logic [LW-1:0]       total_reg, total_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [LW-1:0]       abase_reg, abase_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_st_reg, rsp_st_next;
    logic [BASE_W-1:0]   rsp_base_reg, rsp_base_next;
    logic [COUNT_W-1:0]  rsp_total_reg, rsp_total_next;

    // Decode and helper values.
    logic [WW-1:0] n_w;
    logic [WW-1:0] total_w;
    logic [OI-1:0] want;
    logic          too_big;
    logic [OI-1:0] found;
    logic          found_any;
    logic [OI-1:0] lt_rd_ord;
    logic [LW-1:0] lt_rd;
    logic [WW-1:0] bud_w;
    logic          bud_ok;
    logic [OI-1:0] rel_ord;
    logic          run;
    logic [WW-1:0] blk_mask;
    logic [LW-1:0] rd_nx;
    logic [LW-1:0] rd_pv;
    logic [LW-1:0] rd_nx_c;
    logic [LW-1:0] rd_pv_c;
    logic [WW-1:0] a_size;
    logic [WW-1:0] r_size;
    logic          u_done;

    assign n_w     = WW'(n_reg);
    assign total_w = WW'(total_reg);
    assign rd_nx   = lm_rd_reg[2*LW-1:LW];
    assign rd_pv   = lm_rd_reg[LW-1:0];
    assign rd_nx_c = (rd_nx < NO_PAGE) ? rd_nx : NO_PAGE;
    assign rd_pv_c = (rd_pv < NO_PAGE) ? rd_pv : NO_PAGE;
    assign bud_w   = WW'(m_idx_reg) ^ (WW'(1) << m_ord_reg);
    assign bud_ok  = (bud_w < NP_W) && (m_ord_reg < OI'(MAX_ORDER));
    assign a_size  = WW'(1) << u_ord_reg;
    assign r_size  = WW'(1) << rel_ord;

    // Smallest order whose block holds the request, and the first non-empty
    // list at or above it.
    always_comb
    begin
        want      = OI'(MAX_ORDER);
        found     = '0;
        found_any = 1'b0;
        for (int w = MAX_ORDER; w >= 0; w--)
        begin
            if ((WW'(1) << w) >= n_w)
            begin
                want = OI'(w);
            end
        end
        for (int k = MAX_ORDER; k >= 0; k--)
        begin
            if (OI'(k) >= want && lt_reg[k] != NO_PAGE)
            begin
                found     = OI'(k);
                found_any = 1'b1;
            end
        end
    end
    assign too_big = n_w > (WW'(1) << MAX_ORDER);

    // Largest aligned block that starts the remaining release range.
    always_comb
    begin
        rel_ord  = '0;
        run      = 1'b1;
        blk_mask = '0;
        for (int k = 1; k <= MAX_ORDER; k++)
        begin
            blk_mask = (WW'(1) << k) - WW'(1);
            if (run && (WW'(1) << k) <= rel_n_reg && (rel_idx_reg & blk_mask) == '0)
            begin
                rel_ord = OI'(k);
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    // One read port on the list tops, its order chosen by the state.
    always_comb
    begin
        case (state_reg)
            S_DEC:   lt_rd_ord = found;
            S_U_WR:  lt_rd_ord = u_ord_reg;
            default: lt_rd_ord = m_ord_reg;
        endcase
    end
    assign lt_rd = lt_reg[lt_rd_ord];

    // Memory read address.
    always_comb
    begin
        case (state_reg)
            S_U_RD:     mem_raddr = u_idx_reg;
            S_M_START:  mem_raddr = bud_w[PW-1:0];
            S_U_PV_RD:  mem_raddr = pv_reg[PW-1:0];
            S_U_NX_RD:  mem_raddr = nx_reg[PW-1:0];
            S_P_TOP_RD: mem_raddr = top_reg[PW-1:0];
            default:    mem_raddr = u_idx_reg;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        blk_next       = blk_reg;
        u_idx_next     = u_idx_reg;
        u_ord_next     = u_ord_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        ret_next       = ret_reg;
        m_idx_next     = m_idx_reg;
        m_ord_next     = m_ord_reg;
        top_next       = top_reg;
        rel_idx_next   = rel_idx_reg;
        rel_n_next     = rel_n_reg;
        sw_addr_next   = sw_addr_reg;
        sw_left_next   = sw_left_reg;
        lt_next        = lt_reg;
        total_next     = total_reg;
        st_next        = st_reg;
        abase_next     = abase_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_st_next    = rsp_st_reg;
        rsp_base_next  = rsp_base_reg;
        rsp_total_next = rsp_total_reg;
        fm_we          = 1'b0;
        fm_waddr       = sw_addr_reg;
        fm_wdata       = '0;
        lm_we          = 1'b0;
        lm_waddr       = m_idx_reg;
        lm_wdata       = '0;
        req_ready      = 1'b0;
        u_done         = 1'b0;

        // The response register empties when taken.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            // Clearing pass over the head flags after reset.
            S_INIT:
            begin
                fm_we        = 1'b1;
                sw_addr_next = sw_addr_reg + PW'(1);
                if (sw_addr_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = op;
                    base_next  = base_page;
                    n_next     = page_count;
                    state_next = S_DEC;
                end
            end

            // Check the request and start the matching sequence.
            S_DEC:
            begin
                abase_next = '0;
                if (op_reg != OP_ALLOC && op_reg != OP_FREE && op_reg != OP_ADD
                    || n_reg == '0)
                begin
                    st_next    = ST_BAD;
                    state_next = S_OUT;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    if (n_w > total_w || too_big || !found_any)
                    begin
                        st_next    = ST_NOSPACE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        blk_next   = lt_rd;
                        u_idx_next = lt_rd[PW-1:0];
                        u_ord_next = found;
                        ret_next   = RET_ALLOC;
                        state_next = S_U_RD;
                    end
                end
                else if (WW'(base_reg) + n_w > NP_W || total_w + n_w > NP_W)
                begin
                    st_next    = ST_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    sw_addr_next = PW'(base_reg);
                    sw_left_next = n_w;
                    state_next   = S_SWEEP;
                end
            end

            // Clear the head flag of every page in the released range.
            S_SWEEP:
            begin
                fm_we        = 1'b1;
                sw_addr_next = sw_addr_reg + PW'(1);
                sw_left_next = sw_left_reg - WW'(1);
                if (sw_left_reg == WW'(1))
                begin
                    rel_idx_next = WW'(base_reg);
                    rel_n_next   = n_w;
                    state_next   = S_R_START;
                end
            end

            // Unlink: read the block, drop its flag and fix the list.
            S_U_RD:
            begin
                state_next = S_U_WR;
            end

            S_U_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = u_idx_reg;
                nx_next  = rd_nx_c;
                pv_next  = rd_pv_c;
                if (!(rd_pv < NO_PAGE))
                begin
                    lt_next[u_ord_reg] = rd_nx_c;
                end
                if (rd_pv < NO_PAGE)
                begin
                    state_next = S_U_PV_RD;
                end
                else if (rd_nx < NO_PAGE)
                begin
                    state_next = S_U_NX_RD;
                end
                else
                begin
                    u_done = 1'b1;
                end
            end

            S_U_PV_RD:
            begin
                state_next = S_U_PV_WR;
            end

            S_U_PV_WR:
            begin
                lm_we    = 1'b1;
                lm_waddr = pv_reg[PW-1:0];
                lm_wdata = {nx_reg, rd_pv};
                if (nx_reg < NO_PAGE)
                begin
                    state_next = S_U_NX_RD;
                end
                else
                begin
                    u_done = 1'b1;
                end
            end

            S_U_NX_RD:
            begin
                state_next = S_U_NX_WR;
            end

            S_U_NX_WR:
            begin
                lm_we    = 1'b1;
                lm_waddr = nx_reg[PW-1:0];
                lm_wdata = {rd_nx, pv_reg};
                u_done   = 1'b1;
            end

            // Return the unused suffix of the allocated block.
            S_A_TAIL:
            begin
                if (n_w < a_size && WW'(blk_reg) + a_size <= NP_W)
                begin
                    rel_idx_next = WW'(blk_reg) + n_w;
                    rel_n_next   = a_size - n_w;
                    state_next   = S_R_START;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // Take the next maximal aligned block of the range.
            S_R_START:
            begin
                if (rel_n_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    m_idx_next   = rel_idx_reg[PW-1:0];
                    m_ord_next   = rel_ord;
                    rel_idx_next = rel_idx_reg + r_size;
                    rel_n_next   = rel_n_reg - r_size;
                    state_next   = S_M_START;
                end
            end

            // Probe the buddy at the current order.
            S_M_START:
            begin
                state_next = bud_ok ? S_M_CHK : S_P_WR;
            end

            S_M_CHK:
            begin
                if (fm_rd_reg[FW-1] && fm_rd_reg[ORD_W-1:0] == ORD_W'(m_ord_reg))
                begin
                    u_idx_next = bud_w[PW-1:0];
                    u_ord_next = m_ord_reg;
                    ret_next   = RET_MERGE;
                    state_next = S_U_RD;
                end
                else
                begin
                    state_next = S_P_WR;
                end
            end

            // Push the merged block on its list.
            S_P_WR:
            begin
                fm_we    = 1'b1;
                fm_waddr = m_idx_reg;
                fm_wdata = {1'b1, ORD_W'(m_ord_reg)};
                lm_we    = 1'b1;
                lm_waddr = m_idx_reg;
                lm_wdata = {((lt_rd < NO_PAGE) ? lt_rd : NO_PAGE), NO_PAGE};
                top_next = lt_rd;
                lt_next[m_ord_reg] = LW'(m_idx_reg);
                state_next = (lt_rd < NO_PAGE) ? S_P_TOP_RD : S_R_START;
            end

            S_P_TOP_RD:
            begin
                state_next = S_P_TOP_WR;
            end

            S_P_TOP_WR:
            begin
                lm_we      = 1'b1;
                lm_waddr   = top_reg[PW-1:0];
                lm_wdata   = {rd_nx, LW'(m_idx_reg)};
                state_next = S_R_START;
            end

            // Request done: settle the free total.
            S_FIN:
            begin
                st_next = ST_OK;
                if (op_reg == OP_ALLOC)
                begin
                    total_next = LW'(total_w - n_w);
                    abase_next = blk_reg;
                end
                else
                begin
                    total_next = LW'(total_w + n_w);
                end
                state_next = S_OUT;
            end

            // Load the response once the output register is free.
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_st_next    = st_reg;
                    rsp_base_next  = BASE_W'(abase_reg);
                    rsp_total_next = COUNT_W'(total_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Return from an unlink.
        if (u_done)
        begin
            if (ret_reg == RET_ALLOC)
            begin
                state_next = S_A_TAIL;
            end
            else
            begin
                m_idx_next = (u_idx_reg < m_idx_reg) ? u_idx_reg : m_idx_reg;
                m_ord_next = m_ord_reg + OI'(1);
                state_next = S_M_START;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sw_addr_reg   <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                lt_reg[i] <= NO_PAGE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sw_addr_reg   <= sw_addr_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            lt_reg        <= lt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        base_reg      <= base_next;
        n_reg         <= n_next;
        blk_reg       <= blk_next;
        u_idx_reg     <= u_idx_next;
        u_ord_reg     <= u_ord_next;
        nx_reg        <= nx_next;
        pv_reg        <= pv_next;
        ret_reg       <= ret_next;
        m_idx_reg     <= m_idx_next;
        m_ord_reg     <= m_ord_next;
        top_reg       <= top_next;
        rel_idx_reg   <= rel_idx_next;
        rel_n_reg     <= rel_n_next;
        sw_left_reg   <= sw_left_next;
        st_reg        <= st_next;
        abase_reg     <= abase_next;
        rsp_st_reg    <= rsp_st_next;
        rsp_base_reg  <= rsp_base_next;
        rsp_total_reg <= rsp_total_next;
    end

    // Head-flag memory.
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            flag_mem[fm_waddr] <= fm_wdata;
        end
        fm_rd_reg <= flag_mem[mem_raddr];
    end

    // Link memory.
    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            link_mem[lm_waddr] <= lm_wdata;
        end
        lm_rd_reg <= link_mem[mem_raddr];
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_st_reg;
    assign alloc_base = rsp_base_reg;
    assign free_total = rsp_total_reg;

    // The free total never exceeds the page count.
    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= NO_PAGE)
        else $error("free total above page count");

    // A rejected request leaves the free total alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && st_reg != ST_OK) |-> total_reg == $past(total_reg))
        else $error("free total changed by rejected request");

    // Only a successful request reports an allocation base.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_OK) |-> alloc_base == '0)
        else $error("allocation base on failed request");

endmodule

`default_nettype wire

@@ dv/tb_buddy_page_allocator.sv @@
`default_nettype none

// One expected response, as predicted when its request is accepted.
typedef struct packed {
    logic [1:0]  st;
    logic [15:0] abase;
    logic [16:0] ftotal;
} bpa_rsp_t;

// Scoreboard holding its own copy of the allocator state.
class bpa_scoreboard;
    localparam int unsigned PAGES   = 65536;
    localparam int unsigned TOP_ORD = 16;
    localparam int unsigned NONE    = PAGES;

    bit               blk_head [PAGES];
    logic [4:0]       blk_ord  [PAGES];
    int unsigned      fwd      [PAGES];
    int unsigned      bwd      [PAGES];
    int unsigned      list_top [TOP_ORD + 1];
    int unsigned      ord_pages[TOP_ORD + 1];
    int unsigned      pages_free;
    bpa_rsp_t         pending_rsp[$];
    int               errors;
    int               checked;

    function new();
        for (int i = 0; i <= TOP_ORD; i++)
        begin
            list_top[i]  = NONE;
            ord_pages[i] = 0;
        end
        pages_free = 0;
        errors     = 0;
        checked    = 0;
    endfunction

    // Take a block off the list of its order.
    function void unlink(int unsigned idx, int unsigned ord);
        int unsigned nx;
        int unsigned pv;
        nx = fwd[idx];
        pv = bwd[idx];
        if (pv < NONE)
            fwd[pv] = nx;
        else
            list_top[ord] = (nx < NONE) ? nx : NONE;
        if (nx < NONE)
            bwd[nx] = (pv < NONE) ? pv : NONE;
        ord_pages[ord] -= (1 << ord);
        blk_head[idx] = 0;
        blk_ord[idx]  = 0;
    endfunction

    // Put a block at the top of the list of its order.
    function void push(int unsigned idx, int unsigned ord);
        int unsigned t;
        t = list_top[ord];
        blk_head[idx] = 1;
        blk_ord[idx]  = ord[4:0];
        bwd[idx]      = NONE;
        fwd[idx]      = (t < NONE) ? t : NONE;
        if (t < NONE)
            bwd[t] = idx;
        list_top[ord] = idx;
        ord_pages[ord] += (1 << ord);
    endfunction

    // Merge a block with its free buddies order by order, then list it.
    function void coalesce(int unsigned idx, int unsigned ord);
        int unsigned bud;
        while (ord < TOP_ORD)
        begin
            bud = idx ^ (1 << ord);
            if (bud >= NONE || !blk_head[bud] || blk_ord[bud] != ord[4:0])
                break;
            unlink(bud, ord);
            if (bud < idx)
                idx = bud;
            ord++;
        end
        push(idx, ord);
    endfunction

    // Split a range into maximal aligned blocks and release each one.
    function void release_pages(int unsigned idx, int unsigned n);
        int unsigned ord;
        int unsigned sz;
        int unsigned blk;
        while (n > 0)
        begin
            ord = 0;
            sz  = 1;
            while (ord < TOP_ORD)
            begin
                blk = 1 << (ord + 1);
                if (blk > n || (idx & (blk - 1)) != 0)
                    break;
                ord++;
                sz = blk;
            end
            coalesce(idx, ord);
            idx += sz;
            n   -= sz;
        end
    endfunction

    // Note an accepted request; returns the response it must produce.
    function bpa_rsp_t note(logic [1:0] op, logic [15:0] base, logic [16:0] cnt);
        bpa_rsp_t    r;
        int unsigned n;
        int unsigned want;
        int unsigned found;
        int unsigned blk;
        int unsigned sz;
        n       = cnt;
        r.st    = bpa_pkg::ST_OK;
        r.abase = '0;
        if (op > bpa_pkg::OP_ADD || n == 0)
            r.st = bpa_pkg::ST_BAD;
        else if (op == bpa_pkg::OP_ALLOC)
        begin
            want = 0;
            while (want < TOP_ORD && (1 << want) < n)
                want++;
            found = want;
            while (found <= TOP_ORD && list_top[found] >= NONE)
                found++;
            if (n > pages_free || (1 << want) < n || found > TOP_ORD)
                r.st = bpa_pkg::ST_NOSPACE;
            else
            begin
                blk = list_top[found];
                sz  = 1 << found;
                unlink(blk, found);
                if (n < sz && blk + sz <= PAGES)
                    release_pages(blk + n, sz - n);
                pages_free -= n;
                r.abase = blk[15:0];
            end
        end
        else
        begin
            if (int'(base) + n > PAGES || pages_free + n > PAGES)
                r.st = bpa_pkg::ST_BAD;
            else
            begin
                for (int unsigned i = 0; i < n; i++)
                    blk_head[base + i] = 0;
                release_pages(base, n);
                pages_free += n;
            end
        end
        r.ftotal = pages_free[16:0];
        pending_rsp.push_back(r);
        return r;
    endfunction

    // Compare a taken response with the oldest expectation.
    function void check(logic [1:0] st, logic [15:0] ab, logic [16:0] ft);
        bpa_rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            $display("%0t: response with none expected: status %0d base %0d free %0d",
                     $time, st, ab, ft);
            errors++;
            return;
        end
        e = pending_rsp.pop_front();
        checked++;
        if (st !== e.st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            errors++;
        end
        if (ab !== e.abase)
        begin
            $display("%0t: alloc_base expected %0d actual %0d", $time, e.abase, ab);
            errors++;
        end
        if (ft !== e.ftotal)
        begin
            $display("%0t: free_total expected %0d actual %0d", $time, e.ftotal, ft);
            errors++;
        end
    endfunction
endclass

module tb_buddy_page_allocator;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [OP_W-1:0]     op = OP_ALLOC;
    logic [BASE_W-1:0]   base_page = '0;
    logic [COUNT_W-1:0]  page_count = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   alloc_base;
    logic [COUNT_W-1:0]  free_total;

    bpa_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned run_base[$];
    int unsigned run_len[$];
    int          n_alloc_ok = 0;
    int          n_nospace = 0;
    int          n_bad = 0;
    int          n_freed = 0;

    buddy_page_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .op         (op),
        .base_page  (base_page),
        .page_count (page_count),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .alloc_base (alloc_base),
        .free_total (free_total)
    );

    always #5 clk = ~clk;

    // Receiver with random stalls; responses are checked at the edge that takes them.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check(status, alloc_base, free_total);
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one request, wait for it to be taken, and track allocated runs.
    task automatic send(input logic [1:0] o, input logic [15:0] b, input logic [16:0] c);
        bpa_rsp_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid  <= 1'b1;
        op         <= o;
        base_page  <= b;
        page_count <= c;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        r = sb.note(o, b, c);
        if (r.st == ST_BAD)
            n_bad++;
        else if (r.st == ST_NOSPACE)
            n_nospace++;
        else if (o == OP_ALLOC)
        begin
            n_alloc_ok++;
            run_base.push_back(r.abase);
            run_len.push_back(c);
        end
        else
            n_freed++;
    endtask

    // Hold off the sender until every outstanding response has been taken.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Random allocation size, mostly small with an occasional large one.
    function automatic int unsigned pick_size();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70)
            return $urandom_range(16, 1);
        if (p < 90)
            return $urandom_range(256, 17);
        if (p < 98)
            return $urandom_range(4096, 257);
        return 1 << $urandom_range(14, 8);
    endfunction

    // Release an allocated run, sometimes only a leading part of it.
    task automatic free_run();
        int          k;
        int unsigned b;
        int unsigned len;
        int unsigned part;
        k   = $urandom_range(run_base.size() - 1);
        b   = run_base[k];
        len = run_len[k];
        run_base.delete(k);
        run_len.delete(k);
        part = len;
        if (len > 1 && $urandom_range(9) == 0)
        begin
            part = $urandom_range(len - 1, 1);
            run_base.push_back(b + part);
            run_len.push_back(len - part);
        end
        send(OP_FREE, b[15:0], part[16:0]);
    endtask

    // One random phase: mostly well-formed alloc/free traffic, some noise.
    task automatic random_phase(input int items);
        int unsigned p;
        for (int i = 0; i < items; i++)
        begin
            p = $urandom_range(99);
            if (p < 45 || (p < 90 && run_base.size() == 0))
                send(OP_ALLOC, 16'($urandom), 17'(pick_size()));
            else if (p < 90)
                free_run();
            else if (p < 94)
                send(2'($urandom_range(3)), 16'($urandom), 17'($urandom));
            else if (p < 97)
                send(OP_FREE, 16'($urandom), 17'($urandom_range(8, 1)));
            else
                send(OP_ALLOC, 16'($urandom), 17'($urandom_range(65536, 4097)));
        end
        drain();
    endtask

    // Run-time limit.
    initial
    begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bad requests, extremes and full-range operations.
        send(2'd3, 16'hFFFF, 17'h1FFFF);
        send(OP_ALLOC, 16'd0, 17'd0);
        send(OP_FREE, 16'd5, 17'd0);
        send(OP_ADD, 16'd5, 17'd0);
        send(OP_ALLOC, 16'd0, 17'd1);
        send(OP_ADD, 16'hFFFF, 17'd2);
        send(OP_ADD, 16'hFFFF, 17'd1);
        send(OP_ADD, 16'd0, 17'h1FFFF);
        send(OP_ADD, 16'd0, 17'd65535);
        send(OP_ADD, 16'd0, 17'd1);
        send(OP_ALLOC, 16'd0, 17'd65537);
        send(OP_ALLOC, 16'd0, 17'd65536);
        send(OP_FREE, 16'd0, 17'd65536);
        send(OP_ADD, 16'd100, 17'd1);
        send(OP_ALLOC, 16'd0, 17'd3);
        send(OP_ALLOC, 16'd0, 17'd1);
        send(OP_ALLOC, 16'd0, 17'd5);
        send(OP_ALLOC, 16'hFFFF, 17'd65535);
        send(OP_FREE, 16'd1, 17'd1);
        send(OP_FREE, 16'd1, 17'd1);
        run_base.delete();
        run_len.delete();
        drain();

        // Request the whole range as one allocation, then free the whole range.
        send(OP_ALLOC, 16'd0, 17'd65536);
        drain();
        send(OP_FREE, 16'd0, 17'd65536);
        run_base.delete();
        run_len.delete();

        send_idle_pct = 30;
        recv_idle_pct = 59;
        random_phase(370);
        send_idle_pct = 59;
        recv_idle_pct = 30;
        random_phase(370);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(370);

        repeat (200) @(posedge clk);
        $display("Checked %0d responses: %0d allocations, %0d releases,", sb.checked,
                 n_alloc_ok, n_freed);
        $display("%0d no-space and %0d bad requests, over three idling phases.",
                 n_nospace, n_bad);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/bpa_pkg.sv
hdl/buddy_page_allocator.sv
dv/tb_buddy_page_allocator.sv
